// File: rtl/core/wosc_pkg.sv
// shared types and constants for the wavetable oscillator
package wosc_pkg;

  // fixed field widths
  localparam int FRAC_BITS     = 18;
  localparam int SAMPLE_W      = 32;
  localparam int TABLE_INDEX_W = 9;
  localparam int PHASE_W       = 18;
  localparam int SCALE_W       = 18;
  localparam int LOG_W         = 4;
  localparam int OP_W          = 2;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 18;
  localparam int QUEUE_DEPTH   = 2;

  // operation codes of an input item
  localparam logic [OP_W-1:0] OP_SAMPLE      = 2'd0;
  localparam logic [OP_W-1:0] OP_TABLE_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_SET_PHASE   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP_SCALE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOG_POINTS       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_READY      = 2'd2;

  // command kinds handed from front to back
  typedef enum logic [1:0] {
    CMD_STEP,
    CMD_ZERO,
    CMD_WRITE,
    CMD_PHASE
  } cmd_kind_t;

  // one queued command; data holds increment, table word or phase
  typedef struct packed {
    cmd_kind_t                kind;
    logic [TABLE_INDEX_W-1:0] addr;
    logic [SAMPLE_W-1:0]      data;
  } cmd_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FIRST,
    BK_SECOND
  } back_state_t;

endpackage

// File: rtl/core/wosc_ram.sv
// generic single write, single read ram with registered read data
module wosc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  clk,
  wr_en,
  wr_addr,
  wr_data,
  rd_en,
  rd_addr,
  rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  input  logic             clk;
  input  logic             wr_en;
  input  logic [AW-1:0]    wr_addr;
  input  logic [WIDTH-1:0] wr_data;
  input  logic             rd_en;
  input  logic [AW-1:0]    rd_addr;
  output logic [WIDTH-1:0] rd_data;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/wosc_front.sv
// front end: decodes input items and computes the phase increment
module wosc_front #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [wosc_pkg::OP_W-1:0]           operation,
  input  logic signed [wosc_pkg::SAMPLE_W-1:0] frequency,
  input  logic [wosc_pkg::TABLE_INDEX_W-1:0]  table_index,
  input  logic signed [wosc_pkg::SAMPLE_W-1:0] table_word,
  input  logic [wosc_pkg::PHASE_W-1:0]        phase_value,
  input  logic [wosc_pkg::SCALE_W-1:0]        phase_step_scale,
  input  logic                                table_ready,
  input  logic                                push_ready,
  output logic                                push,
  output wosc_pkg::cmd_t                      push_cmd
);
  import wosc_pkg::*;

  localparam int PROD_W = SAMPLE_W + SCALE_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic                     in_range;
  logic                     keep;

  // scale times frequency; the low phase bits of the floored shift form the increment
  assign prod     = $signed({1'b0, phase_step_scale}) * frequency;
  assign in_range = 32'(table_index) < TABLE_DEPTH;
  assign in_ready = push_ready;

  // classify the item
  always_comb begin
    keep          = 1'b0;
    push_cmd.kind = CMD_STEP;
    push_cmd.addr = table_index;
    push_cmd.data = SAMPLE_W'(prod[FRAC_BITS +: FRAC_BITS]);
    unique case (operation)
      OP_SAMPLE: begin
        keep          = 1'b1;
        push_cmd.kind = table_ready ? CMD_STEP : CMD_ZERO;
      end
      OP_TABLE_WRITE: begin
        keep          = in_range;
        push_cmd.kind = CMD_WRITE;
        push_cmd.data = table_word;
      end
      OP_SET_PHASE: begin
        keep          = 1'b1;
        push_cmd.kind = CMD_PHASE;
        push_cmd.data = SAMPLE_W'(phase_value);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = in_valid && in_ready && keep;

endmodule

// File: rtl/core/wosc_queue.sv
// short command queue between front and back
module wosc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wosc_pkg::cmd_t push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output wosc_pkg::cmd_t pop_cmd,
  input  logic           pop
);
  import wosc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// File: rtl/core/wosc_back.sv
// back end: phase accumulator, table access and interpolation
module wosc_back #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  wosc_pkg::cmd_t                       cmd,
  output logic                                 cmd_pop,
  input  logic [wosc_pkg::LOG_W-1:0]           log_points,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wosc_pkg::SAMPLE_W-1:0] sample_out
);
  import wosc_pkg::*;

  localparam int AW        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FLOOR_LOG = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int LMAX_RAW  = (FLOOR_LOG < FRAC_BITS) ? FLOOR_LOG : FRAC_BITS;
  localparam int LMAX      = (LMAX_RAW < 1) ? 1 : LMAX_RAW;
  localparam int LW        = $clog2(LMAX + 1);
  localparam int SHW       = $clog2(FRAC_BITS + 1);
  localparam int WW        = FRAC_BITS + 1;
  localparam int PROD_W    = SAMPLE_W + WW + 1;
  localparam logic [WW-1:0] ONE_Q = WW'(1) << FRAC_BITS;

  back_state_t state;
  back_state_t state_next;

  logic [FRAC_BITS-1:0] phase;
  logic [FRAC_BITS-1:0] phase_next;
  logic [FRAC_BITS-1:0] frac;
  logic [FRAC_BITS-1:0] frac_next;
  logic [AW-1:0]        upper_addr;
  logic [AW-1:0]        upper_addr_next;
  logic [AW-1:0]        lower_addr;
  logic [AW-1:0]        pts_mask;
  logic [LW-1:0]        eff_l;
  logic [SHW-1:0]       shamt;

  logic signed [SAMPLE_W-1:0] term0;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [WW-1:0]              weight;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] prod_term;

  logic          slot_free;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic          load_phase;
  logic          step_start;
  logic          load_zero;
  logic          load_sample;

  // table memory
  wosc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(cmd.addr)),
    .wr_data (cmd.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // effective table size, saturated to the supported range
  always_comb begin
    if (log_points == '0) begin
      eff_l = LW'(1);
    end else if (32'(log_points) > LMAX) begin
      eff_l = LW'(LMAX);
    end else begin
      eff_l = LW'(log_points);
    end
  end

  // new phase, entry index, fraction and neighbor index
  assign phase_next      = phase + cmd.data[FRAC_BITS-1:0];
  assign shamt           = SHW'(FRAC_BITS) - SHW'(eff_l);
  assign lower_addr      = AW'(phase_next >> shamt);
  assign frac_next       = phase_next << eff_l;
  assign pts_mask        = AW'((32'd1 << eff_l) - 32'd1);
  assign upper_addr_next = (lower_addr + AW'(1)) & pts_mask;

  // shared multiplier: entry times weight, floored by the fraction width
  assign prod      = rd_data * $signed({1'b0, weight});
  assign prod_term = prod[FRAC_BITS +: SAMPLE_W];
  assign slot_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && cmd.kind == CMD_STEP) begin
          state_next = BK_FIRST;
        end
      end
      BK_FIRST: begin
        state_next = BK_SECOND;
      end
      BK_SECOND: begin
        if (slot_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    cmd_pop     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = lower_addr;
    wr_en       = 1'b0;
    load_phase  = 1'b0;
    step_start  = 1'b0;
    load_zero   = 1'b0;
    load_sample = 1'b0;
    weight      = ONE_Q - {1'b0, frac};
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.kind)
            CMD_STEP: begin
              cmd_pop    = 1'b1;
              rd_en      = 1'b1;
              step_start = 1'b1;
            end
            CMD_ZERO: begin
              cmd_pop   = slot_free;
              load_zero = slot_free;
            end
            CMD_WRITE: begin
              cmd_pop = 1'b1;
              wr_en   = 1'b1;
            end
            CMD_PHASE: begin
              cmd_pop    = 1'b1;
              load_phase = 1'b1;
            end
          endcase
        end
      end
      BK_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = upper_addr;
      end
      BK_SECOND: begin
        weight      = {1'b0, frac};
        load_sample = slot_free;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_phase) begin
        phase <= cmd.data[FRAC_BITS-1:0];
      end else if (step_start) begin
        phase <= phase_next;
      end
      if (load_zero || load_sample) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (step_start) begin
      frac       <= frac_next;
      upper_addr <= upper_addr_next;
    end
    if (state == BK_FIRST) begin
      term0 <= prod_term;
    end
    if (load_zero) begin
      sample_out <= '0;
    end else if (load_sample) begin
      sample_out <= term0 + prod_term;
    end
  end

  // the second read always follows a first read issued from idle
  a_first_from_idle: assert property (@(posedge clk) disable iff (rst)
    state == BK_FIRST |-> $past(state) == BK_IDLE)
    else $error("second table read without a preceding first read");

  // the table memory never reads and writes together
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("table read and write in the same cycle");

  // neighbor index stays within the entries in use
  a_upper_in_use: assert property (@(posedge clk) disable iff (rst)
    state == BK_FIRST |-> (upper_addr & ~pts_mask) == '0)
    else $error("neighbor index outside the table in use");

  // a result appears only after interpolation or a zero command
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == BK_SECOND
                         || $past(cmd_pop && cmd.kind == CMD_ZERO))
    else $error("result without a producing command");

endmodule

// File: rtl/core/wavetable_oscillator_interp_unit.sv
// top level of the linear-interpolating wavetable oscillator
// a sample step passes the back-end sequencer states idle, first and second, which share one
//   multiplier and the table read port; the next command is taken only once it is idle again;
//   table writes and phase sets retire one per cycle while the back end is idle
// reset: phase clears to zero, queue and output empty, configuration to defaults;
//   table contents are not cleared and read as undefined until written
module wavetable_oscillator_interp_unit #(
  parameter int TABLE_DEPTH = 512
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [wosc_pkg::OP_W-1:0]            operation,
  input  logic signed [wosc_pkg::SAMPLE_W-1:0] frequency,
  input  logic [wosc_pkg::TABLE_INDEX_W-1:0]   table_index,
  input  logic signed [wosc_pkg::SAMPLE_W-1:0] table_word,
  input  logic [wosc_pkg::PHASE_W-1:0]         phase_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wosc_pkg::SAMPLE_W-1:0] sample_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wosc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wosc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import wosc_pkg::*;

  logic [SCALE_W-1:0] phase_step_scale;
  logic [LOG_W-1:0]   log_points;
  logic               table_ready;

  logic push;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  cmd_t pop_cmd;
  logic cmd_pop;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step_scale <= SCALE_W'(6);
      log_points       <= LOG_W'(9);
      table_ready      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PHASE_STEP_SCALE: phase_step_scale <= cfg_data[SCALE_W-1:0];
        CFG_LOG_POINTS:       log_points       <= cfg_data[LOG_W-1:0];
        CFG_TABLE_READY:      table_ready      <= cfg_data[0];
        default:              table_ready      <= table_ready;
      endcase
    end
  end

  // item decode
  wosc_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .frequency        (frequency),
    .table_index      (table_index),
    .table_word       (table_word),
    .phase_value      (phase_value),
    .phase_step_scale (phase_step_scale),
    .table_ready      (table_ready),
    .push_ready       (push_ready),
    .push             (push),
    .push_cmd         (push_cmd)
  );

  // command queue
  wosc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (cmd_pop)
  );

  // execution
  wosc_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (pop_valid),
    .cmd        (pop_cmd),
    .cmd_pop    (cmd_pop),
    .log_points (log_points),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

endmodule

// File: tb/sv/tb_wavetable_oscillator_interp_unit.sv
// testbench for the linear-interpolating wavetable oscillator
module tb_wavetable_oscillator_interp_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import wosc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int TABLE_DEPTH   = 512;
  localparam int MAX_LOG       = $clog2(TABLE_DEPTH);
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_PRINTS    = 20;
  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam logic [PHASE_W-1:0] PHASE_TOP = '1;

  // one input transaction plus the sample it should produce
  typedef struct {
    logic [OP_W-1:0]            op;
    logic signed [SAMPLE_W-1:0] freq;
    logic [TABLE_INDEX_W-1:0]   idx;
    logic signed [SAMPLE_W-1:0] word;
    logic [PHASE_W-1:0]         phase;
    bit                         has_result;
    logic signed [SAMPLE_W-1:0] sample;
    bit                         hold_for_drain;
  } osc_item_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [OP_W-1:0]              operation = '0;
  logic signed [SAMPLE_W-1:0]   frequency = '0;
  logic [TABLE_INDEX_W-1:0]     table_index = '0;
  logic signed [SAMPLE_W-1:0]   table_word = '0;
  logic [PHASE_W-1:0]           phase_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_out;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  // oscillator state as the testbench sees it
  logic [SCALE_W-1:0]           scale_reg = 18'd6;
  logic [LOG_W-1:0]             log_reg = 4'd9;
  logic                         ready_reg = 1'b0;
  logic [PHASE_W-1:0]           osc_phase = '0;
  logic signed [SAMPLE_W-1:0]   wave_mem [TABLE_DEPTH];
  bit                           wave_written [TABLE_DEPTH];

  osc_item_t                    pending_items[$];
  osc_item_t                    cur_item;
  logic signed [SAMPLE_W-1:0]   sample_expect_q[$];
  logic signed [SAMPLE_W-1:0]   want_sample;

  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  int  sent_results = 0;
  int  got_results = 0;
  int  accepted_count = 0;
  int  error_count = 0;
  int  items_made = 0;
  int  ignored_made = 0;
  int  reg_writes = 0;
  int  settings_run = 0;
  int  cycle_count = 0;
  int  rx_hold_left = 0;
  bit  long_hold_armed = 1'b0;
  bit  long_hold_done = 1'b0;

  wavetable_oscillator_interp_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .frequency   (frequency),
    .table_index (table_index),
    .table_word  (table_word),
    .phase_value (phase_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // log2 of the table entries in use after saturation
  function automatic int unsigned eff_log_points();
    int unsigned l;
    l = log_reg;
    if (l < 1) l = 1;
    if (l > MAX_LOG) l = MAX_LOG;
    return l;
  endfunction

  // phase after one step at the given frequency, floor rounding of the increment
  function automatic logic [PHASE_W-1:0] next_phase(input logic signed [SAMPLE_W-1:0] freq);
    longint inc;
    inc = (longint'(scale_reg) * longint'(freq)) >>> FRAC_BITS;
    return osc_phase + inc[PHASE_W-1:0];
  endfunction

  // entry index, its neighbor (wrapping at the last entry) and the Q18 fraction
  function automatic void phase_taps(input logic [PHASE_W-1:0] ph, output int unsigned off,
                                     output int unsigned nxt, output longint frac);
    int unsigned l;
    l = eff_log_points();
    off = ph >> (FRAC_BITS - l);
    frac = (longint'(ph) << l) & ((longint'(1) << FRAC_BITS) - 1);
    nxt = (off + 1 == (1 << l)) ? 0 : off + 1;
  endfunction

  // advance the oscillator by one transaction and fill in the expected sample
  function automatic osc_item_t predict_osc(input osc_item_t it);
    int unsigned off, nxt;
    longint frac, sum;
    it.has_result = 1'b0;
    it.sample = '0;
    case (it.op)
      OP_TABLE_WRITE: begin
        wave_mem[it.idx] = it.word;
        wave_written[it.idx] = 1'b1;
      end
      OP_SET_PHASE: osc_phase = it.phase;
      OP_SAMPLE: begin
        it.has_result = 1'b1;
        if (ready_reg) begin
          osc_phase = next_phase(it.freq);
          phase_taps(osc_phase, off, nxt, frac);
          sum = ((longint'(wave_mem[off]) * ((longint'(1) << FRAC_BITS) - frac)) >>> FRAC_BITS)
              + ((longint'(wave_mem[nxt]) * frac) >>> FRAC_BITS);
          it.sample = sum[SAMPLE_W-1:0];
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  // queue one transaction; a step that would read an unwritten entry gets it written first
  function automatic void add_item(input logic [OP_W-1:0] op,
                                   input logic signed [SAMPLE_W-1:0] freq,
                                   input logic [TABLE_INDEX_W-1:0] idx,
                                   input logic signed [SAMPLE_W-1:0] word,
                                   input logic [PHASE_W-1:0] ph, input bit hold = 1'b0);
    osc_item_t it;
    int unsigned off, nxt;
    longint frac;
    if (op == OP_SAMPLE && ready_reg) begin
      phase_taps(next_phase(freq), off, nxt, frac);
      if (!wave_written[off]) add_item(OP_TABLE_WRITE, $urandom(), off, $urandom(), $urandom());
      if (!wave_written[nxt]) add_item(OP_TABLE_WRITE, $urandom(), nxt, $urandom(), $urandom());
    end
    it.op = op;
    it.freq = freq;
    it.idx = idx;
    it.word = word;
    it.phase = ph;
    it.hold_for_drain = hold;
    pending_items.push_back(predict_osc(it));
    if (op == OP_RESERVED) ignored_made++;
    else items_made++;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_freq();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3, 4, 5: return $urandom();
      6, 7:    return $signed($urandom_range(2 ** 25 - 1)) - 32'sd16777216;
      default: return $signed($urandom_range(600)) - 32'sd300;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_word();
    if ($urandom_range(3) == 0) return $signed($urandom_range(2 ** 21 - 1)) - 32'sd1048576;
    return $urandom();
  endfunction

  // wait until nothing is queued or outstanding, then let the pipeline settle
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || sample_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_index <= index;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CFG_PHASE_STEP_SCALE: scale_reg = value;
      CFG_LOG_POINTS:       log_reg = value[LOG_W-1:0];
      CFG_TABLE_READY:      ready_reg = value[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // one setting of the registers followed by a random mix of transactions
  task automatic run_setting(input logic [CFG_DATA_W-1:0] scale, input logic [CFG_DATA_W-1:0] logp,
                             input logic [CFG_DATA_W-1:0] rdy, input int tx_pct, input int rx_pct,
                             input int count, input bit long_hold);
    int made;
    int pick;
    int unsigned l;
    wait_idle();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_reg(CFG_PHASE_STEP_SCALE, scale);
    write_reg(CFG_LOG_POINTS, logp);
    write_reg(CFG_TABLE_READY, rdy);
    settings_run++;
    @(negedge clk);
    if (long_hold) long_hold_armed = 1'b1;
    l = eff_log_points();
    // last entry wraps to entry zero
    add_item(OP_SET_PHASE, $urandom(), $urandom(), $urandom(), PHASE_TOP);
    add_item(OP_SAMPLE, '0, $urandom(), $urandom(), $urandom());
    made = 2;
    while (made < count) begin
      pick = $urandom_range(99);
      // the midpoint is always a step that waits for every earlier result
      if (pick < 68 || made == count / 2) begin
        add_item(OP_SAMPLE, rand_freq(), $urandom(), $urandom(), $urandom(), made == count / 2);
        made++;
      end else if (pick < 82) begin
        add_item(OP_TABLE_WRITE, $urandom(),
                 ($urandom_range(3) == 0) ? $urandom_range(TABLE_DEPTH - 1)
                                          : $urandom_range((1 << l) - 1),
                 rand_word(), $urandom());
        made++;
      end else if (pick < 94) begin
        add_item(OP_SET_PHASE, $urandom(), $urandom(), $urandom(), $urandom());
        made++;
      end else begin
        add_item(OP_RESERVED, $urandom(), $urandom(), $urandom(), $urandom());
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 7;
    rx_idle_pct = 81;
    @(negedge clk);

    // no table bound: zero output, phase holds
    add_item(OP_SAMPLE, 32'sh7FFF_FFFF, '0, '0, '0);
    add_item(OP_SAMPLE, 32'sh8000_0000, '1, '1, '1);
    add_item(OP_TABLE_WRITE, '0, '0, 32'sh7FFF_FFFF, '0);
    add_item(OP_TABLE_WRITE, '1, 9'd511, 32'sh8000_0000, '1);
    add_item(OP_SET_PHASE, '0, '0, '0, PHASE_TOP);
    add_item(OP_RESERVED, $urandom(), $urandom(), $urandom(), $urandom());
    add_item(OP_SAMPLE, '0, '0, '0, '0);

    // two-entry table, full scale
    wait_idle();
    write_reg(CFG_TABLE_READY, 1);
    write_reg(CFG_LOG_POINTS, 1);
    write_reg(CFG_PHASE_STEP_SCALE, '1);
    settings_run++;
    @(negedge clk);
    add_item(OP_TABLE_WRITE, '0, 9'd1, 32'sh8000_0000, '0);
    add_item(OP_SET_PHASE, '0, '0, '0, '0);
    add_item(OP_SAMPLE, '0, '0, '0, '0);
    add_item(OP_SET_PHASE, '0, '0, '0, PHASE_TOP);
    add_item(OP_SAMPLE, '0, '0, '0, '0);
    add_item(OP_SAMPLE, -32'sd1, '0, '0, '0);
    add_item(OP_SAMPLE, 32'sh7FFF_FFFF, '0, '0, '0);
    add_item(OP_SAMPLE, 32'sh8000_0000, '0, '0, '0);
    add_item(OP_TABLE_WRITE, '0, 9'd1, -32'sd1, '0);
    add_item(OP_SET_PHASE, '0, '0, '0, 18'h20000);
    add_item(OP_SAMPLE, '0, '0, '0, '0);
    add_item(OP_SAMPLE, 32'sd1, '0, '0, '0);

    // random settings; idling shifts from receiver to sender to none
    run_setting(18'd6, 18'd9, 18'd1, 7, 81, 200, 1'b0);
    run_setting('1, 18'd15, 18'd1, 7, 81, 180, 1'b0);
    run_setting($urandom_range(2 ** 18 - 1), 18'd0, 18'd1, 81, 7, 180, 1'b0);
    run_setting('0, 18'd4, 18'd1, 81, 7, 100, 1'b0);
    run_setting($urandom_range(2 ** 18 - 1), 18'd9, 18'd0, 81, 7, 60, 1'b0);
    run_setting($urandom_range(2 ** 18 - 1), $urandom_range(MAX_LOG, 1), 18'd1, 0, 0, 180, 1'b1);
    run_setting($urandom_range(4096), 18'd3, 18'd1, 0, 0, 180, 1'b0);

    wait_idle();
    $display("run covered %0d transactions (%0d ignored ones besides, %0d accepted in all),",
             items_made, ignored_made, accepted_count);
    $display("  %0d samples checked, %0d register writes over %0d settings, %0d errors",
             got_results, reg_writes, settings_run, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // input driver: offers the next queued transaction, may idle or wait for a drain
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur_item.has_result) begin
          sample_expect_q.push_back(cur_item.sample);
          sent_results++;
        end
        accepted_count <= accepted_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
            !(pending_items[0].hold_for_drain && sent_results != got_results)) begin
          cur_item = pending_items.pop_front();
          operation <= cur_item.op;
          frequency <= cur_item.freq;
          table_index <= cur_item.idx;
          table_word <= cur_item.word;
          phase_value <= cur_item.phase;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the block fills and backs up its input
  always @(posedge clk) begin
    if (rst) begin
      rx_hold_left <= 0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (long_hold_armed && !long_hold_done) begin
      rx_hold_left <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end
  end

  // output monitor: compare each sample with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (sample_expect_q.size() == 0) begin
          report_mismatch($sformatf("sample %0d with nothing expected", sample_out));
        end else begin
          want_sample = sample_expect_q.pop_front();
          if (sample_out !== want_sample) begin
            report_mismatch($sformatf("sample_out %0d, expected %0d", sample_out, want_sample));
          end
        end
        got_results <= got_results + 1;
      end
      out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycle_count,
               sample_expect_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
